// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk outside reset.
`define CHK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Implication: when the trigger holds, the consequence holds in the next cycle.
`define CHK_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/bmm_pkg.sv =====
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared types and constants of the block RMS / min / max level meter.
// ----------------------------------------------------------------------------
package bmm_pkg;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned OFFSET_W = 16;
	localparam int unsigned LEVEL_W  = 16;
	localparam int unsigned SQ_W     = 31;	// offset square: up to 2^30 + 65535
	localparam int unsigned ROOT_IN_W = 2 * LEVEL_W;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} sample_in_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] max_level;
		logic [LEVEL_W-1:0] min_level;
		logic [LEVEL_W-1:0] rms_level;
	} levels_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_RSTART,
		BK_ROOT,
		BK_OUT
	} back_state_t;

endpackage

// ===== design/block_rms_min_max_meter.sv =====
// ----------------------------------------------------------------------------
// block_rms_min_max_meter: block RMS / min / max audio level meter
// Throughput: one sample per cycle while the statistics queue has room; each block
//   passes a SUM_W-step serial divider, then 16-step root units, so short blocks stall.
// Reset: asynchronous, active low; clears pipeline, queue, sequencer and offset.
// ----------------------------------------------------------------------------
module block_rms_min_max_meter import bmm_pkg::*; #(
	parameter int unsigned MAX_BLOCK = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [OFFSET_W-1:0] cfg_wdata,
	input  logic                item_valid,
	input  sample_in_t          item,
	output logic                item_stall,
	output logic                levels_valid,
	input  logic                levels_stall,
	output levels_t             levels
);

	// sample count must hold MAX_BLOCK itself; the sum of MAX_BLOCK offset
	// squares, each below 2^31, fits SQ_W + CNT_W bits
	localparam int unsigned CNT_W = $clog2(MAX_BLOCK + 1);
	localparam int unsigned SUM_W = SQ_W + CNT_W;
	localparam int unsigned REC_W = SUM_W + 2 * SQ_W + CNT_W;

	logic             push;
	logic [SUM_W-1:0] push_sum;
	logic [SQ_W-1:0]  push_max;
	logic [SQ_W-1:0]  push_min;
	logic [CNT_W-1:0] push_cnt;
	logic             q_full;
	logic             q_empty;
	logic             pop;
	logic [REC_W-1:0] pop_rec;

	// Front: two-stage squaring pipeline feeding the accumulators. It only
	// stalls when a block end finds the statistics queue full.
	bmm_front #(
		.MAX_BLOCK (MAX_BLOCK),
		.CNT_W     (CNT_W),
		.SUM_W     (SUM_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.q_full     (q_full),
		.push       (push),
		.push_sum   (push_sum),
		.push_max   (push_max),
		.push_min   (push_min),
		.push_cnt   (push_cnt)
	);

	// Decouples the per-sample front from the per-block back end.
	bmm_queue #(
		.W (REC_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_sum, push_max, push_min, push_cnt}),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_rec),
		.empty     (q_empty)
	);

	// Back: mean by serial division, three floor roots, result held until
	// the sink takes the transaction.
	bmm_back #(
		.CNT_W (CNT_W),
		.SUM_W (SUM_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_sum        (pop_rec[REC_W-1 -: SUM_W]),
		.q_max        (pop_rec[2*SQ_W+CNT_W-1 -: SQ_W]),
		.q_min        (pop_rec[SQ_W+CNT_W-1 -: SQ_W]),
		.q_cnt        (pop_rec[CNT_W-1:0]),
		.pop          (pop),
		.levels_valid (levels_valid),
		.levels_stall (levels_stall),
		.levels       (levels)
	);

endmodule

// ===== design/bmm_front.sv =====
// ----------------------------------------------------------------------------
// bmm_front
// Sample intake: squaring pipeline, offset add and per-block statistics.
// Pushes one statistics record into the queue at every block end.
// ----------------------------------------------------------------------------
module bmm_front import bmm_pkg::*; #(
	parameter int unsigned MAX_BLOCK = 4096,
	parameter int unsigned CNT_W     = 13,
	parameter int unsigned SUM_W     = 44
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [OFFSET_W-1:0] cfg_wdata,
	input  logic                item_valid,
	input  sample_in_t          item,
	output logic                item_stall,
	input  logic                q_full,
	output logic                push,
	output logic [SUM_W-1:0]    push_sum,
	output logic [SQ_W-1:0]     push_max,
	output logic [SQ_W-1:0]     push_min,
	output logic [CNT_W-1:0]    push_cnt
);

	logic [OFFSET_W-1:0] offset_q;

	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                last_s1;

	logic                valid_s2;
	logic [SQ_W-1:0]     sq_s2;
	logic                last_s2;

	logic [SUM_W-1:0]    sum_q;
	logic [SQ_W-1:0]     max_q;
	logic [SQ_W-1:0]     min_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                fresh_q;	// next sample opens a new block

	logic [SAMPLE_W-1:0] mag;
	logic [2*SAMPLE_W-1:0] prod;
	logic [SQ_W-1:0]     osq;
	logic [SUM_W-1:0]    cur_sum;
	logic [SQ_W-1:0]     cur_max;
	logic [SQ_W-1:0]     cur_min;
	logic [CNT_W-1:0]    cur_cnt;
	logic                blk_end;
	logic                adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	// magnitude: -32768 maps to 32768, which still fits 16 bits unsigned
	assign mag  = sample_s1[SAMPLE_W-1] ? (~sample_s1 + 16'd1) : sample_s1;
	assign prod = (2*SAMPLE_W)'(mag) * (2*SAMPLE_W)'(mag);

	assign osq     = sq_s2 + SQ_W'(offset_q);
	assign cur_sum = (fresh_q ? '0 : sum_q) + SUM_W'(osq);
	assign cur_max = (fresh_q || (osq > max_q)) ? osq : max_q;
	assign cur_min = (fresh_q || (osq < min_q)) ? osq : min_q;
	assign cur_cnt = (fresh_q ? '0 : cnt_q) + CNT_W'(1);
	assign blk_end = last_s2 || (cur_cnt == CNT_W'(MAX_BLOCK));

	// whole pipeline holds only when a block end meets a full queue
	assign adv        = !(valid_s2 && blk_end && q_full);
	assign item_stall = !adv;

	assign push     = valid_s2 && blk_end && adv;
	assign push_sum = cur_sum;
	assign push_max = cur_max;
	assign push_min = cur_min;
	assign push_cnt = cur_cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			fresh_q  <= 1'b1;
		end else if (adv) begin
			valid_s1 <= item_valid;
			valid_s2 <= valid_s1;
			if (valid_s2) begin
				fresh_q <= blk_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s1 <= item.sample;
			last_s1   <= item.last;
			sq_s2     <= prod[SQ_W-1:0];
			last_s2   <= last_s1;
			if (valid_s2) begin
				sum_q <= cur_sum;
				max_q <= cur_max;
				min_q <= cur_min;
				cnt_q <= cur_cnt;
			end
		end
	end

endmodule

// ===== design/bmm_queue.sv =====
// ----------------------------------------------------------------------------
// bmm_queue
// Two-entry queue of block statistics between front and back.
// ----------------------------------------------------------------------------
module bmm_queue #(
	parameter int unsigned W = 119
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/bmm_sqrt.sv =====
// ----------------------------------------------------------------------------
// bmm_sqrt
// Iterative floor square root of a 32-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module bmm_sqrt import bmm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [ROOT_IN_W-1:0] value,
	output logic                 busy,
	output logic [LEVEL_W-1:0]   root
);

	localparam int unsigned STEP_W = $clog2(LEVEL_W + 1);

	logic [ROOT_IN_W-1:0] val_q;
	logic [LEVEL_W:0]     rem_q;
	logic [LEVEL_W-1:0]   root_q;
	logic [STEP_W-1:0]    cnt_q;

	logic [LEVEL_W+2:0]   r2;
	logic [LEVEL_W+2:0]   trial;
	logic                 fits;

	assign r2    = {rem_q, val_q[ROOT_IN_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign fits  = (r2 >= trial);

	assign busy = (cnt_q != '0);
	assign root = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= STEP_W'(LEVEL_W);
		end else if (busy) begin
			cnt_q <= cnt_q - STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy) begin
			val_q  <= {val_q[ROOT_IN_W-3:0], 2'b00};
			rem_q  <= fits ? (LEVEL_W+1)'(r2 - trial) : r2[LEVEL_W:0];
			root_q <= {root_q[LEVEL_W-2:0], fits};
		end
	end

endmodule

// ===== design/bmm_back.sv =====
// ----------------------------------------------------------------------------
// bmm_back
// Result engine: pops block statistics, divides sum by count bit-serially,
// then runs three root units in parallel and holds the result for the sink.
// ----------------------------------------------------------------------------
module bmm_back import bmm_pkg::*; #(
	parameter int unsigned CNT_W = 13,
	parameter int unsigned SUM_W = 44
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  logic [SUM_W-1:0] q_sum,
	input  logic [SQ_W-1:0]  q_max,
	input  logic [SQ_W-1:0]  q_min,
	input  logic [CNT_W-1:0] q_cnt,
	output logic             pop,
	output logic             levels_valid,
	input  logic             levels_stall,
	output levels_t          levels
);

	localparam int unsigned STEP_W = $clog2(SUM_W);

	back_state_t state_q, state_d;

	logic [SUM_W-1:0]  dq_q;	// dividend shifts out, quotient shifts in
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [STEP_W-1:0] step_q;
	logic [SQ_W-1:0]   max_q;
	logic [SQ_W-1:0]   min_q;

	logic [CNT_W:0]    shifted;
	logic              q_bit;
	logic              div_last;

	logic              load;
	logic              div_run;
	logic              root_start;
	logic [2:0]        root_busy;

	assign shifted  = {rem_q, dq_q[SUM_W-1]};
	assign q_bit    = (shifted >= {1'b0, div_q});
	assign div_last = (step_q == STEP_W'(SUM_W - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE:   if (!q_empty) state_d = BK_DIV;
			BK_DIV:    if (div_last) state_d = BK_RSTART;
			BK_RSTART: state_d = BK_ROOT;
			BK_ROOT:   if (root_busy == 3'b000) state_d = BK_OUT;
			BK_OUT:    if (!levels_stall) state_d = BK_IDLE;
			default:   state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		load         = 1'b0;
		div_run      = 1'b0;
		root_start   = 1'b0;
		levels_valid = 1'b0;
		case (state_q)
			BK_IDLE:   load = !q_empty;
			BK_DIV:    div_run = 1'b1;
			BK_RSTART: root_start = 1'b1;
			BK_OUT:    levels_valid = 1'b1;
			default:   ;
		endcase
	end

	assign pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dq_q   <= q_sum;
			div_q  <= q_cnt;
			rem_q  <= '0;
			step_q <= '0;
			max_q  <= q_max;
			min_q  <= q_min;
		end else if (div_run) begin
			dq_q   <= {dq_q[SUM_W-2:0], q_bit};
			rem_q  <= q_bit ? CNT_W'(shifted - {1'b0, div_q}) : shifted[CNT_W-1:0];
			step_q <= step_q + STEP_W'(1);
		end
	end

	// the mean never exceeds the largest square, so it fits SQ_W bits
	bmm_sqrt u_root_max (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.value  ({1'b0, max_q}),
		.busy   (root_busy[0]),
		.root   (levels.max_level)
	);

	bmm_sqrt u_root_min (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.value  ({1'b0, min_q}),
		.busy   (root_busy[1]),
		.root   (levels.min_level)
	);

	bmm_sqrt u_root_rms (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.value  ({1'b0, dq_q[SQ_W-1:0]}),
		.busy   (root_busy[2]),
		.root   (levels.rms_level)
	);

endmodule

// ===== design/bmm_checker.sv =====
// ----------------------------------------------------------------------------
// bmm_checker
// Port-level checks of the level meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmm_checker import bmm_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    levels_valid,
	input logic    levels_stall,
	input levels_t levels
);

	`CHK_NEXT(a_out_valid_hold, levels_valid && levels_stall, levels_valid, "result valid dropped while stalled")
	`CHK_NEXT(a_out_data_hold, levels_valid && levels_stall, $stable(levels), "stalled result changed")
	`CHK_ASSERT(a_level_order, !levels_valid || ((levels.max_level >= levels.rms_level) && (levels.rms_level >= levels.min_level)), "rms level outside min/max")
	`CHK_NEXT(a_result_spacing, $fell(levels_valid), !levels_valid, "back-to-back results without computation")

endmodule

bind block_rms_min_max_meter bmm_checker u_bmm_checker (.*);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for block_rms_min_max_meter
// Feeds signed samples in blocks to the meter under bursty traffic with a
// stalling receiver. An in-bench level predictor gives the expected
// max / min / rms levels, and each result is checked in order as it arrives.
// The square offset register is swept across phases.
// ----------------------------------------------------------------------------
module tb;
	import bmm_pkg::*;

	localparam int unsigned MAX_BLOCK = 4096;
	localparam int unsigned COUNT_W   = $clog2(MAX_BLOCK) + 1;	// 13 at default
	localparam int unsigned SUM_W     = SQ_W + COUNT_W;		// 44 at default
	localparam int          DRAIN_CYCLES = 100;
	localparam int          RANDOM_PHASE_ITEMS = 240;

	// sample content styles for generated blocks
	typedef enum int {
		MIX_FULL,	// any 16-bit value
		MIX_QUIET,	// tiny magnitudes, many ties
		MIX_EXTREME,	// full-scale and near-zero corners
		MIX_FLAT	// one value repeated
	} content_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [OFFSET_W-1:0] cfg_wdata = '0;
	logic                item_valid = 1'b0;
	sample_in_t          item = '0;
	logic                item_stall;
	logic                levels_valid;
	logic                levels_stall = 1'b0;
	levels_t             levels;

	block_rms_min_max_meter #(
		.MAX_BLOCK (MAX_BLOCK)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item         (item),
		.item_stall   (item_stall),
		.levels_valid (levels_valid),
		.levels_stall (levels_stall),
		.levels       (levels)
	);

	// ------------------------------------------------------------------
	// Level predictor: its own copy of the offset and the block statistics
	// ------------------------------------------------------------------
	logic [OFFSET_W-1:0] offset_setting  = '0;
	logic [SUM_W-1:0]    energy_sum      = '0;
	logic [SQ_W-1:0]     largest_square  = '0;
	logic [SQ_W-1:0]     smallest_square = '1;
	logic [COUNT_W-1:0]  sample_count    = '0;

	sample_in_t sample_feed[$];	// samples waiting to be driven
	levels_t    levels_due[$];	// predicted results, oldest first
	int         mismatches = 0;

	// floor square root, one result bit per step from the top
	function automatic logic [LEVEL_W-1:0] floor_sqrt(input logic [SQ_W-1:0] v);
		logic [LEVEL_W-1:0] root;
		logic [LEVEL_W-1:0] trial;
		root = '0;
		for (int b = LEVEL_W - 1; b >= 0; b--) begin
			trial = root | (LEVEL_W'(1) << b);
			if (64'(trial) * 64'(trial) <= 64'(v))
				root = trial;
		end
		return root;
	endfunction

	// Fold one accepted sample into the block; on a block end push the levels.
	function automatic void accumulate_sample(input sample_in_t s);
		logic [SQ_W-1:0] mag;
		logic [SQ_W-1:0] sq;
		logic [SQ_W-1:0] mean;
		levels_t         lv;
		if (s.sample[SAMPLE_W-1])
			mag = SQ_W'(0) - SQ_W'($signed(s.sample));
		else
			mag = SQ_W'(s.sample);
		sq = mag * mag + SQ_W'(offset_setting);

		energy_sum = energy_sum + SUM_W'(sq);
		if (sq > largest_square)
			largest_square = sq;
		if (sq < smallest_square)
			smallest_square = sq;
		sample_count = sample_count + 1'b1;

		// a block also closes when it reaches the maximum length
		if (s.last || sample_count == COUNT_W'(MAX_BLOCK)) begin
			mean = SQ_W'(energy_sum / SUM_W'(sample_count));
			lv.max_level = floor_sqrt(largest_square);
			lv.min_level = floor_sqrt(smallest_square);
			lv.rms_level = floor_sqrt(mean);
			levels_due.push_back(lv);
			energy_sum      = '0;
			largest_square  = '0;
			smallest_square = '1;
			sample_count    = '0;
		end
	endfunction

	// ------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// Driver: bursts of random length separated by random gaps. A stalled
	// transaction holds its payload; the predictor sees each sample on the
	// edge where it is accepted.
	// ------------------------------------------------------------------
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (item_valid && item_stall !== 1'b0) begin
			// stalled: keep valid and payload as they are
		end else begin
			if (item_valid)
				accumulate_sample(item);
			if (gap_left > 0 || sample_feed.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				item_valid <= 1'b0;
			end else begin
				item       <= sample_feed.pop_front();
				item_valid <= 1'b1;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 48);
					// a quarter of the bursts run straight into the next one
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each accepted result against the oldest prediction,
	// and drives the receiver stall. The stall density is redrawn periodically,
	// from none at all up to heavy back-pressure.
	// ------------------------------------------------------------------
	int stall_pct   = 0;
	int stall_epoch = 0;

	function automatic void check_level(input string field, input logic [LEVEL_W-1:0] want,
			input logic [LEVEL_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		levels_t want;
		if (arst_n && levels_valid === 1'b1 && !levels_stall) begin
			if (levels_due.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual max %0d min %0d rms %0d",
					$time, levels.max_level, levels.min_level, levels.rms_level);
				mismatches++;
			end else begin
				want = levels_due.pop_front();
				check_level("max_level", want.max_level, levels.max_level);
				check_level("min_level", want.min_level, levels.min_level);
				check_level("rms_level", want.rms_level, levels.rms_level);
			end
		end
		stall_epoch++;
		if (stall_epoch % 300 == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 85;
			endcase
		end
		levels_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_sample(input logic [SAMPLE_W-1:0] v, input bit is_last);
		sample_in_t s;
		s.sample = v;
		s.last   = is_last;
		sample_feed.push_back(s);
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample(input content_t mix,
			input logic [SAMPLE_W-1:0] flat);
		logic [SAMPLE_W-1:0] corners[6];
		corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8001};
		case (mix)
			MIX_QUIET:   return SAMPLE_W'($urandom_range(0, 16) - 8);
			MIX_EXTREME: return corners[$urandom_range(0, 5)];
			MIX_FLAT:    return flat;
			default:     return SAMPLE_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// one block of len samples; close_it puts last on the final sample
	task automatic add_block(input int len, input bit close_it, input content_t mix);
		logic [SAMPLE_W-1:0] flat;
		flat = SAMPLE_W'($urandom_range(0, 65535));
		for (int i = 0; i < len; i++)
			push_sample(pick_sample(mix, flat), close_it && (i == len - 1));
	endtask

	// random blocks, mostly short since the back end works on one block at a time
	task automatic add_random_blocks(input int n_items);
		int added;
		int len;
		int pick;
		added = 0;
		while (added < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				len = $urandom_range(1, 16);
			else if (pick < 95)
				len = $urandom_range(17, 200);
			else
				len = $urandom_range(201, 600);
			add_block(len, 1'b1, content_t'($urandom_range(0, 3)));
			added += len;
		end
	endtask

	// wait for every sample to go in and every result to come out, then let
	// the back end settle
	task automatic wait_drained();
		do
			@(negedge clk);
		while (sample_feed.size() != 0 || item_valid || levels_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write; only called while the meter is idle
	task automatic write_offset(input logic [OFFSET_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		offset_setting = v;
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		wait (arst_n === 1'b1);

		// reset offset of zero: single-sample blocks at the corners
		push_sample(16'h0000, 1'b1);
		push_sample(16'h8000, 1'b1);	// -32768, square is 2^30
		push_sample(16'h7FFF, 1'b1);
		push_sample(16'hFFFF, 1'b1);	// -1
		// mixed block: max, min and mean all differ
		push_sample(16'h7FFF, 1'b0);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h0000, 1'b0);
		push_sample(16'h0001, 1'b1);
		// equal magnitudes of both signs
		push_sample(16'd100, 1'b0);
		push_sample(-16'sd100, 1'b0);
		push_sample(16'd100, 1'b1);
		wait_drained();

		// largest offset: corners again, the top square reaches 2^30 + 65535
		write_offset(16'hFFFF);
		push_sample(16'h0000, 1'b1);
		push_sample(16'h8000, 1'b1);
		push_sample(16'h8001, 1'b0);
		push_sample(16'h0003, 1'b0);
		push_sample(16'h7FFF, 1'b1);
		add_block(5, 1'b1, MIX_FULL);
		wait_drained();

		write_offset(OFFSET_W'($urandom_range(0, 65535)));
		add_random_blocks(RANDOM_PHASE_ITEMS);
		wait_drained();

		write_offset(16'h0001);
		add_random_blocks(RANDOM_PHASE_ITEMS);
		wait_drained();

		write_offset(16'h0000);
		add_random_blocks(RANDOM_PHASE_ITEMS);
		wait_drained();

		write_offset(OFFSET_W'($urandom_range(0, 65535)));
		add_random_blocks(RANDOM_PHASE_ITEMS);
		wait_drained();

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog, several times the slowest expected run
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/bmm_pkg.sv
design/bmm_front.sv
design/bmm_queue.sv
design/bmm_sqrt.sv
design/bmm_back.sv
design/block_rms_min_max_meter.sv
design/bmm_checker.sv
tb/tb.sv
